>>> hw/rtl/tsch_pkg.sv
// shared widths, codes and table transfer types for the task scheduler tick block
// no dependencies
package tsch_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int SLOT_W     = $clog2(NUM_TASKS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int TIME_W     = 16;
    localparam int BURST_W    = 8;
    localparam int PRIO_W     = 8;
    localparam int MODE_W     = 3;
    localparam int REQ_W      = 2;
    localparam int QNT_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_PRIO    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PRIO_PR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SJF     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SRTF    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FCFS    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RR      = 3'd5;

    localparam logic [REQ_W-1:0] REQ_ADD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHED_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_QUANTUM = 1'd1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic               add_en;
        logic               rem_en;
        logic [SLOT_W-1:0]  idx;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] rem;
        logic [TIME_W-1:0]  arrival;
        logic [PRIO_W-1:0]  prio;
    } tbl_wr_t;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] rem;
        logic [TIME_W-1:0]  arrival;
        logic [PRIO_W-1:0]  prio;
    } tbl_rd_t;

endpackage

>>> hw/rtl/tsch_table.sv
// task table: original burst, remaining burst, arrival and priority per slot
// depends on tsch_pkg
module tsch_table
    import tsch_pkg::*;
(
    input  logic              clk,
    input  tbl_wr_t           wr,
    input  logic [SLOT_W-1:0] rd_idx,
    output tbl_rd_t           rd
);

    logic [BURST_W-1:0] orig_mem  [NUM_TASKS];
    logic [BURST_W-1:0] rem_mem   [NUM_TASKS];
    logic [TIME_W-1:0]  arr_mem   [NUM_TASKS];
    logic [PRIO_W-1:0]  prio_mem  [NUM_TASKS];

    always_ff @(posedge clk)
    begin
        if (wr.add_en)
        begin
            orig_mem[wr.idx] <= wr.burst;
            arr_mem[wr.idx]  <= wr.arrival;
            prio_mem[wr.idx] <= wr.prio;
        end
        if (wr.add_en || wr.rem_en)
        begin
            rem_mem[wr.idx] <= wr.rem;
        end
    end

    // single read port, at the scan slot or, while a popped entry is checked, at the popped slot
    assign rd.burst   = orig_mem[rd_idx];
    assign rd.rem     = rem_mem[rd_idx];
    assign rd.arrival = arr_mem[rd_idx];
    assign rd.prio    = prio_mem[rd_idx];

endmodule

>>> hw/rtl/task_scheduler_tick.sv
// top level of the task scheduler tick block: sequencer, ready fifo, result registers
// depends on tsch_pkg and tsch_table
//
// One request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with out_valid high, and cannot be held off.
// An add or unknown request is answered straight from idle; a restart walks the
// used slots once to reload remaining bursts. A tick walks the used slots once
// to queue newly eligible tasks, once more to select under priority, SJF, SRTF
// or FCFS unless the running task keeps running (round robin instead pops the
// ready fifo, one entry per ST_POPRD/ST_POPCHK pair), then executes and takes
// the turnaround in ST_EXEC and the waiting time in ST_FIN; the table's one read
// port is walked slot by slot. A tick that finds no running task walks the table
// once more to detect that all work is done.
module task_scheduler_tick
    import tsch_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [BURST_W-1:0]    burst_time,
    input  logic [TIME_W-1:0]     arrival_time,
    input  logic [PRIO_W-1:0]     priority_level,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  out_valid,
    output logic                  run_valid,
    output logic [SLOT_W-1:0]     run_slot,
    output logic [TIME_W-1:0]     now_time,
    output logic                  done_valid,
    output logic [TIME_W-1:0]     turnaround,
    output logic [TIME_W-1:0]     waiting,
    output logic                  all_done,
    output logic                  table_full
);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ENQ    = 4'd1;
    localparam logic [3:0] ST_DECIDE = 4'd2;
    localparam logic [3:0] ST_POPRD  = 4'd3;
    localparam logic [3:0] ST_POPCHK = 4'd4;
    localparam logic [3:0] ST_SEL    = 4'd5;
    localparam logic [3:0] ST_TAKE   = 4'd6;
    localparam logic [3:0] ST_EXEC   = 4'd7;
    localparam logic [3:0] ST_FIN    = 4'd8;
    localparam logic [3:0] ST_ANY    = 4'd9;
    localparam logic [3:0] ST_RST    = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    tcount_reg, tcount_next;
    logic                rv_reg, rv_next;
    logic [SLOT_W-1:0]   rs_reg, rs_next;
    logic [TIME_W-1:0]   tick_reg, tick_next;
    logic [QNT_W-1:0]    ql_reg, ql_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [NUM_TASKS-1:0] qmask_reg, qmask_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [QNT_W-1:0]    tq_reg, tq_next;

    // cached fields of the running task
    logic [BURST_W-1:0]  run_rem_reg, run_rem_next;
    logic [BURST_W-1:0]  run_orig_reg, run_orig_next;
    logic [TIME_W-1:0]   run_arr_reg, run_arr_next;
    logic [PRIO_W-1:0]   run_prio_reg, run_prio_next;

    // selection scan
    logic                found_reg, found_next;
    logic [BURST_W:0]    bound_reg, bound_next;
    logic [SLOT_W-1:0]   best_reg, best_next;
    logic [BURST_W-1:0]  best_rem_reg, best_rem_next;
    logic [BURST_W-1:0]  best_orig_reg, best_orig_next;
    logic [TIME_W-1:0]   best_arr_reg, best_arr_next;
    logic [PRIO_W-1:0]   best_prio_reg, best_prio_next;

    logic [TIME_W-1:0]   tat_reg, tat_next;
    logic                fin_done_reg, fin_done_next;
    logic                any_reg, any_next;
    logic [SLOT_W-1:0]   pop_slot_reg;

    logic                out_valid_reg, out_valid_next;
    logic                o_run_reg, o_run_next;
    logic [SLOT_W-1:0]   o_slot_reg, o_slot_next;
    logic [TIME_W-1:0]   o_now_reg, o_now_next;
    logic                o_done_reg, o_done_next;
    logic [TIME_W-1:0]   o_tat_reg, o_tat_next;
    logic [TIME_W-1:0]   o_wait_reg, o_wait_next;
    logic                o_all_reg, o_all_next;
    logic                o_full_reg, o_full_next;

    logic [SLOT_W-1:0]   fifo_mem [NUM_TASKS];
    logic                push_en;
    logic [SLOT_W-1:0]   push_slot;
    logic                pop_en;

    tbl_wr_t             tbl_wr;
    tbl_rd_t             tbl_rd;
    logic [SLOT_W-1:0]   rd_idx;

    logic [SLOT_W-1:0]   scan_idx;
    logic                scan_last;
    logic                elig;
    logic                not_running;
    logic [MODE_W-1:0]   mode_eff;
    logic                m_prio, m_sjf, m_rr, m_preempt;
    logic                fifo_room;
    logic [BURST_W-1:0]  new_rem;
    logic [TIME_W:0]     tat_wide;
    logic [TIME_W-1:0]   tick_inc;

    tsch_table u_table (
        .clk    (clk),
        .wr     (tbl_wr),
        .rd_idx (rd_idx),
        .rd     (tbl_rd)
    );

    assign scan_idx  = cnt_reg[SLOT_W-1:0];
    assign scan_last = ((cnt_reg + CNT_W'(1)) == tcount_reg);
    assign rd_idx    = (state_reg == ST_POPCHK) ? pop_slot_reg : scan_idx;

    // eligible: arrived and still has work
    assign elig        = (tbl_rd.arrival <= tick_reg) && (tbl_rd.rem != '0);
    assign not_running = !(rv_reg && (scan_idx == rs_reg));

    assign mode_eff  = (mode_reg > MODE_RR) ? MODE_FCFS : mode_reg;
    assign m_prio    = (mode_eff == MODE_PRIO) || (mode_eff == MODE_PRIO_PR);
    assign m_sjf     = (mode_eff == MODE_SJF) || (mode_eff == MODE_SRTF);
    assign m_rr      = (mode_eff == MODE_RR);
    assign m_preempt = (mode_eff == MODE_PRIO_PR) || (mode_eff == MODE_SRTF) || m_rr;

    assign fifo_room = (fill_reg < CNT_W'(NUM_TASKS));
    assign new_rem   = run_rem_reg - BURST_W'(1);
    assign tat_wide  = {1'b0, tick_reg} + (TIME_W+1)'(1) - {1'b0, run_arr_reg};
    assign tick_inc  = (tick_reg != TIME_MAX) ? tick_reg + TIME_W'(1) : tick_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tcount_next    = tcount_reg;
        rv_next        = rv_reg;
        rs_next        = rs_reg;
        tick_next      = tick_reg;
        ql_next        = ql_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        qmask_next     = qmask_reg;
        mode_next      = mode_reg;
        tq_next        = tq_reg;
        run_rem_next   = run_rem_reg;
        run_orig_next  = run_orig_reg;
        run_arr_next   = run_arr_reg;
        run_prio_next  = run_prio_reg;
        found_next     = found_reg;
        bound_next     = bound_reg;
        best_next      = best_reg;
        best_rem_next  = best_rem_reg;
        best_orig_next = best_orig_reg;
        best_arr_next  = best_arr_reg;
        best_prio_next = best_prio_reg;
        tat_next       = tat_reg;
        fin_done_next  = fin_done_reg;
        any_next       = any_reg;
        out_valid_next = 1'b0;
        o_run_next     = o_run_reg;
        o_slot_next    = o_slot_reg;
        o_now_next     = o_now_reg;
        o_done_next    = o_done_reg;
        o_tat_next     = o_tat_reg;
        o_wait_next    = o_wait_reg;
        o_all_next     = o_all_reg;
        o_full_next    = o_full_reg;
        push_en        = 1'b0;
        push_slot      = scan_idx;
        pop_en         = 1'b0;
        tbl_wr         = '0;
        tbl_wr.idx     = scan_idx;

        // configuration writes, to be made only while idle; the block does not enforce it
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SCHED_MODE:   mode_next = cfg_wdata[MODE_W-1:0];
                CFG_TIME_QUANTUM: tq_next = (cfg_wdata == '0) ? QNT_W'(1) : cfg_wdata;
                default:          ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // a result defaults to all zero but now_time
                    o_run_next  = 1'b0;
                    o_slot_next = '0;
                    o_now_next  = tick_reg;
                    o_done_next = 1'b0;
                    o_tat_next  = '0;
                    o_wait_next = '0;
                    o_all_next  = 1'b0;
                    o_full_next = 1'b0;
                    cnt_next    = '0;
                    unique case (req_type)
                        REQ_ADD:
                        begin
                            if (tcount_reg >= CNT_W'(NUM_TASKS))
                            begin
                                o_full_next = 1'b1;
                            end
                            else
                            begin
                                tbl_wr.add_en  = 1'b1;
                                tbl_wr.idx     = tcount_reg[SLOT_W-1:0];
                                tbl_wr.burst   = burst_time;
                                tbl_wr.rem     = burst_time;
                                tbl_wr.arrival = arrival_time;
                                tbl_wr.prio    = priority_level;
                                tcount_next    = tcount_reg + CNT_W'(1);
                            end
                            out_valid_next = 1'b1;
                        end
                        REQ_TICK:
                        begin
                            state_next = (tcount_reg != '0) ? ST_ENQ : ST_DECIDE;
                        end
                        REQ_RESTART:
                        begin
                            tick_next  = '0;
                            rv_next    = 1'b0;
                            rs_next    = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            fill_next  = '0;
                            qmask_next = '0;
                            ql_next    = tq_reg;
                            o_now_next = '0;
                            if (tcount_reg != '0)
                            begin
                                state_next = ST_RST;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_RST:
            begin
                // reload remaining burst from original burst
                tbl_wr.rem_en = 1'b1;
                tbl_wr.rem    = tbl_rd.burst;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (scan_last)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_ENQ:
            begin
                // queue every newly eligible task that is not running
                if (elig && not_running && !qmask_reg[scan_idx] && fifo_room)
                begin
                    push_en               = 1'b1;
                    push_slot             = scan_idx;
                    tail_next             = (tail_reg == SLOT_W'(NUM_TASKS-1)) ?
                                            '0 : tail_reg + SLOT_W'(1);
                    fill_next             = fill_reg + CNT_W'(1);
                    qmask_next[scan_idx]  = 1'b1;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                cnt_next = '0;
                if (rv_reg && !(m_preempt && (m_prio || m_sjf || (m_rr && ql_reg == '0))))
                begin
                    state_next = ST_EXEC;
                end
                else if (m_rr)
                begin
                    // expired quantum: running task goes back to the tail
                    if (rv_reg && ql_reg == '0 && run_rem_reg != '0)
                    begin
                        if (!qmask_reg[rs_reg] && fifo_room)
                        begin
                            push_en            = 1'b1;
                            push_slot          = rs_reg;
                            tail_next          = (tail_reg == SLOT_W'(NUM_TASKS-1)) ?
                                                 '0 : tail_reg + SLOT_W'(1);
                            fill_next          = fill_reg + CNT_W'(1);
                            qmask_next[rs_reg] = 1'b1;
                        end
                        rv_next = 1'b0;
                    end
                    state_next = ST_POPRD;
                end
                else
                begin
                    found_next = 1'b0;
                    if (rv_reg)
                    begin
                        bound_next = m_prio ? {1'b0, run_prio_reg} : {1'b0, run_rem_reg};
                    end
                    else
                    begin
                        bound_next = {1'b1, {BURST_W{1'b0}}};
                    end
                    state_next = (tcount_reg != '0) ? ST_SEL : ST_EXEC;
                end
            end

            ST_POPRD:
            begin
                if (rv_reg || fill_reg == '0)
                begin
                    state_next = ST_EXEC;
                end
                else
                begin
                    pop_en     = 1'b1;
                    head_next  = (head_reg == SLOT_W'(NUM_TASKS-1)) ?
                                 '0 : head_reg + SLOT_W'(1);
                    fill_next  = fill_reg - CNT_W'(1);
                    state_next = ST_POPCHK;
                end
            end

            ST_POPCHK:
            begin
                // stale entries are dropped
                qmask_next[pop_slot_reg] = 1'b0;
                if (({1'b0, pop_slot_reg} < tcount_reg) && tbl_rd.rem != '0)
                begin
                    rv_next       = 1'b1;
                    rs_next       = pop_slot_reg;
                    run_rem_next  = tbl_rd.rem;
                    run_orig_next = tbl_rd.burst;
                    run_arr_next  = tbl_rd.arrival;
                    run_prio_next = tbl_rd.prio;
                    ql_next       = tq_reg;
                end
                state_next = ST_POPRD;
            end

            ST_SEL:
            begin
                if (elig && not_running)
                begin
                    if (m_prio)
                    begin
                        if ({1'b0, tbl_rd.prio} < bound_reg)
                        begin
                            bound_next = {1'b0, tbl_rd.prio};
                            found_next = 1'b1;
                            best_next  = scan_idx;
                        end
                    end
                    else if (m_sjf)
                    begin
                        if ({1'b0, tbl_rd.rem} < bound_reg)
                        begin
                            bound_next = {1'b0, tbl_rd.rem};
                            found_next = 1'b1;
                            best_next  = scan_idx;
                        end
                        else if (found_reg && {1'b0, tbl_rd.rem} == bound_reg &&
                                 tbl_rd.arrival < best_arr_reg)
                        begin
                            best_next = scan_idx;
                        end
                    end
                    else
                    begin
                        if (!found_reg || tbl_rd.arrival < best_arr_reg)
                        begin
                            found_next = 1'b1;
                            best_next  = scan_idx;
                        end
                    end
                    if (best_next == scan_idx && (found_next != found_reg ||
                        best_next != best_reg || !found_reg))
                    begin
                        best_rem_next  = tbl_rd.rem;
                        best_orig_next = tbl_rd.burst;
                        best_arr_next  = tbl_rd.arrival;
                        best_prio_next = tbl_rd.prio;
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (scan_last)
                begin
                    state_next = ST_TAKE;
                end
            end

            ST_TAKE:
            begin
                // a find always beats the running task, since the bound started there
                if (found_reg)
                begin
                    rv_next       = 1'b1;
                    rs_next       = best_reg;
                    run_rem_next  = best_rem_reg;
                    run_orig_next = best_orig_reg;
                    run_arr_next  = best_arr_reg;
                    run_prio_next = best_prio_reg;
                end
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                if (rv_reg)
                begin
                    tbl_wr.rem_en = 1'b1;
                    tbl_wr.idx    = rs_reg;
                    tbl_wr.rem    = new_rem;
                    run_rem_next  = new_rem;
                    if (m_rr && ql_reg != '0)
                    begin
                        ql_next = ql_reg - QNT_W'(1);
                    end
                    fin_done_next = (new_rem == '0);
                    if (new_rem == '0)
                    begin
                        rv_next  = 1'b0;
                        tat_next = tat_wide[TIME_W] ? TIME_MAX : tat_wide[TIME_W-1:0];
                    end
                    state_next = ST_FIN;
                end
                else if (tcount_reg != '0)
                begin
                    any_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_ANY;
                end
                else
                begin
                    o_all_next     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_FIN:
            begin
                o_run_next  = 1'b1;
                o_slot_next = rs_reg;
                o_done_next = fin_done_reg;
                if (fin_done_reg)
                begin
                    o_tat_next  = tat_reg;
                    o_wait_next = (tat_reg > TIME_W'(run_orig_reg)) ?
                                  tat_reg - TIME_W'(run_orig_reg) : '0;
                end
                tick_next      = tick_inc;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_ANY:
            begin
                // nothing ran: check whether any task still has work
                if (tbl_rd.rem != '0)
                begin
                    any_next = 1'b1;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (scan_last)
                begin
                    if (any_reg || tbl_rd.rem != '0)
                    begin
                        tick_next = tick_inc;
                    end
                    else
                    begin
                        o_all_next = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ready fifo storage with registered read
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            fifo_mem[tail_reg] <= push_slot;
        end
        if (pop_en)
        begin
            pop_slot_reg <= fifo_mem[head_reg];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tcount_reg    <= '0;
            rv_reg        <= 1'b0;
            rs_reg        <= '0;
            tick_reg      <= '0;
            ql_reg        <= QNT_W'(1);
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            qmask_reg     <= '0;
            mode_reg      <= MODE_FCFS;
            tq_reg        <= QNT_W'(1);
            found_reg     <= 1'b0;
            fin_done_reg  <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tcount_reg    <= tcount_next;
            rv_reg        <= rv_next;
            rs_reg        <= rs_next;
            tick_reg      <= tick_next;
            ql_reg        <= ql_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            qmask_reg     <= qmask_next;
            mode_reg      <= mode_next;
            tq_reg        <= tq_next;
            found_reg     <= found_next;
            fin_done_reg  <= fin_done_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        run_rem_reg   <= run_rem_next;
        run_orig_reg  <= run_orig_next;
        run_arr_reg   <= run_arr_next;
        run_prio_reg  <= run_prio_next;
        bound_reg     <= bound_next;
        best_reg      <= best_next;
        best_rem_reg  <= best_rem_next;
        best_orig_reg <= best_orig_next;
        best_arr_reg  <= best_arr_next;
        best_prio_reg <= best_prio_next;
        tat_reg       <= tat_next;
        o_run_reg     <= o_run_next;
        o_slot_reg    <= o_slot_next;
        o_now_reg     <= o_now_next;
        o_done_reg    <= o_done_next;
        o_tat_reg     <= o_tat_next;
        o_wait_reg    <= o_wait_next;
        o_all_reg     <= o_all_next;
        o_full_reg    <= o_full_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign run_valid  = o_run_reg;
    assign run_slot   = o_slot_reg;
    assign now_time   = o_now_reg;
    assign done_valid = o_done_reg;
    assign turnaround = o_tat_reg;
    assign waiting    = o_wait_reg;
    assign all_done   = o_all_reg;
    assign table_full = o_full_reg;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for task_scheduler_tick: table of directed requests, then random phases
// depends on tsch_pkg and the task_scheduler_tick rtl
`timescale 1ns / 100ps

module tb_top;
    import tsch_pkg::*;

    // request code the block ignores
    localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

    // one result of the block, all fields packed for compare
    typedef struct packed {
        logic              rv;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now;
        logic              dv;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
        logic              ad;
        logic              tf;
    } sched_res_t;

    // directed stimulus row; has_res marks a typed-in result
    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arr;
        logic [PRIO_W-1:0]  prio;
        bit                 has_res;
        sched_res_t         res;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [REQ_W-1:0]      req_type;
    logic [BURST_W-1:0]    burst_time;
    logic [TIME_W-1:0]     arrival_time;
    logic [PRIO_W-1:0]     priority_level;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  out_valid;
    logic                  run_valid;
    logic [SLOT_W-1:0]     run_slot;
    logic [TIME_W-1:0]     now_time;
    logic                  done_valid;
    logic [TIME_W-1:0]     turnaround;
    logic [TIME_W-1:0]     waiting;
    logic                  all_done;
    logic                  table_full;

    task_scheduler_tick i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .burst_time     (burst_time),
        .arrival_time   (arrival_time),
        .priority_level (priority_level),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (out_valid),
        .run_valid      (run_valid),
        .run_slot       (run_slot),
        .now_time       (now_time),
        .done_valid     (done_valid),
        .turnaround     (turnaround),
        .waiting        (waiting),
        .all_done       (all_done),
        .table_full     (table_full)
    );

    // ---------------------------------------------------------------------
    // scheduler shadow state, kept at the block's widths
    // ---------------------------------------------------------------------
    logic [BURST_W-1:0] sh_orig  [NUM_TASKS];
    logic [BURST_W-1:0] sh_rem   [NUM_TASKS];
    logic [TIME_W-1:0]  sh_arr   [NUM_TASKS];
    logic [PRIO_W-1:0]  sh_prio  [NUM_TASKS];
    logic [SLOT_W-1:0]  sh_fifo  [NUM_TASKS];
    logic [NUM_TASKS-1:0] sh_queued;
    logic [CNT_W-1:0]   sh_count;
    logic               sh_run_v;
    logic [SLOT_W-1:0]  sh_run_s;
    logic [TIME_W-1:0]  sh_tick;
    logic [QNT_W-1:0]   sh_qleft;
    logic [SLOT_W-1:0]  sh_head;
    logic [SLOT_W-1:0]  sh_tail;
    logic [CNT_W-1:0]   sh_fill;
    logic [MODE_W-1:0]  sh_mode;
    logic [QNT_W-1:0]   sh_quantum;

    sched_res_t pending_res[$];
    int         fail_count;
    int         cycle_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic bit is_eligible(input int i);
        return sh_arr[i] <= sh_tick && sh_rem[i] > 0;
    endfunction

    // ready fifo: a slot already queued, or a full fifo, is skipped
    function automatic void ready_push(input int s);
        if (sh_queued[s] || sh_fill >= NUM_TASKS)
            return;
        sh_fifo[sh_tail] = s[SLOT_W-1:0];
        sh_tail++;
        sh_fill++;
        sh_queued[s] = 1'b1;
    endfunction

    function automatic int ready_pop();
        int s;
        s = sh_fifo[sh_head];
        sh_head++;
        sh_fill--;
        sh_queued[s] = 1'b0;
        return s;
    endfunction

    // one time tick under the current policy
    function automatic void tick_sched(inout sched_res_t r);
        logic [MODE_W-1:0] m;
        bit   prio_m, sjf_m, rr_m, pre_m, found, take, any_left;
        int   n, best, bound, s, i, tat;
        m = (sh_mode > MODE_RR) ? MODE_FCFS : sh_mode;
        prio_m = (m == MODE_PRIO || m == MODE_PRIO_PR);
        sjf_m  = (m == MODE_SJF || m == MODE_SRTF);
        rr_m   = (m == MODE_RR);
        pre_m  = (m == MODE_PRIO_PR || m == MODE_SRTF || m == MODE_RR);
        n = sh_count;
        r.now = sh_tick;
        // queue newly eligible tasks
        for (i = 0; i < n; i++)
            if (is_eligible(i) && !(sh_run_v && i == sh_run_s))
                ready_push(i);
        if (!sh_run_v || (pre_m && (prio_m || sjf_m || (rr_m && sh_qleft == 0)))) begin
            if (rr_m) begin
                if (sh_run_v && sh_qleft == 0 && sh_rem[sh_run_s] > 0) begin
                    ready_push(sh_run_s);
                    sh_run_v = 1'b0;
                end
                // stale entries with no work left are dropped
                while (!sh_run_v && sh_fill > 0) begin
                    s = ready_pop();
                    if (s < n && sh_rem[s] > 0) begin
                        sh_run_s = s[SLOT_W-1:0];
                        sh_run_v = 1'b1;
                        sh_qleft = sh_quantum;
                    end
                end
            end else begin
                found = 0;
                best  = 0;
                bound = 256;
                if (sh_run_v)
                    bound = prio_m ? sh_prio[sh_run_s] : sh_rem[sh_run_s];
                for (i = 0; i < n; i++) begin
                    if (!is_eligible(i) || (sh_run_v && i == sh_run_s))
                        continue;
                    if (prio_m) begin
                        if (sh_prio[i] < bound) begin
                            bound = sh_prio[i];
                            best  = i;
                            found = 1;
                        end
                    end else if (sjf_m) begin
                        if (sh_rem[i] < bound) begin
                            bound = sh_rem[i];
                            best  = i;
                            found = 1;
                        end else if (found && sh_rem[i] == bound && sh_arr[i] < sh_arr[best])
                            best = i;
                    end else if (!found || sh_arr[i] < sh_arr[best]) begin
                        // fcfs, ties stay with the lower slot
                        best  = i;
                        found = 1;
                    end
                end
                if (found) begin
                    take = !sh_run_v;
                    if (sh_run_v && pre_m) begin
                        if (prio_m && sh_prio[best] < sh_prio[sh_run_s])
                            take = 1;
                        if (sjf_m && sh_rem[best] < sh_rem[sh_run_s])
                            take = 1;
                    end
                    if (take) begin
                        sh_run_s = best[SLOT_W-1:0];
                        sh_run_v = 1'b1;
                    end
                end
            end
        end
        if (sh_run_v) begin
            s = sh_run_s;
            r.rv   = 1'b1;
            r.slot = sh_run_s;
            if (sh_rem[s] > 0)
                sh_rem[s]--;
            if (rr_m && sh_qleft > 0)
                sh_qleft--;
            if (sh_rem[s] == 0) begin
                tat = int'(sh_tick) + 1 - int'(sh_arr[s]);
                if (tat > TIME_MAX)
                    tat = TIME_MAX;
                r.dv  = 1'b1;
                r.tat = tat[TIME_W-1:0];
                r.wt  = (tat > sh_orig[s]) ? TIME_W'(tat - sh_orig[s]) : '0;
                sh_run_v = 1'b0;
            end
        end else begin
            any_left = 0;
            for (i = 0; i < n; i++)
                if (sh_rem[i] > 0)
                    any_left = 1;
            if (!any_left) begin
                r.ad = 1'b1;
                return;
            end
        end
        if (sh_tick != TIME_MAX)
            sh_tick++;
    endfunction

    // expected result of one accepted request; updates the shadow state
    function automatic sched_res_t sched_predict(input logic [REQ_W-1:0] rq,
                                                 input logic [BURST_W-1:0] b,
                                                 input logic [TIME_W-1:0] a,
                                                 input logic [PRIO_W-1:0] p);
        sched_res_t r;
        int i;
        r = '0;
        r.now = sh_tick;
        case (rq)
            REQ_ADD: begin
                if (sh_count >= NUM_TASKS)
                    r.tf = 1'b1;
                else begin
                    sh_orig[sh_count] = b;
                    sh_rem[sh_count]  = b;
                    sh_arr[sh_count]  = a;
                    sh_prio[sh_count] = p;
                    sh_count++;
                end
            end
            REQ_TICK: tick_sched(r);
            REQ_RESTART: begin
                for (i = 0; i < sh_count; i++)
                    sh_rem[i] = sh_orig[i];
                sh_tick   = '0;
                sh_run_v  = 1'b0;
                sh_run_s  = '0;
                sh_head   = '0;
                sh_tail   = '0;
                sh_fill   = '0;
                sh_queued = '0;
                sh_qleft  = sh_quantum;
                r.now     = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // clock, cycle limit
    // ---------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // limit sized for about 1000 requests plus their random gaps
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // result checker: every strobed result against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_res_t w;
        if (rst_n && out_valid)
        begin
            if (pending_res.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                w = pending_res.pop_front();
                if (run_valid !== w.rv)      report_mismatch("run_valid", run_valid, w.rv);
                if (run_slot !== w.slot)     report_mismatch("run_slot", run_slot, w.slot);
                if (now_time !== w.now)      report_mismatch("now_time", now_time, w.now);
                if (done_valid !== w.dv)     report_mismatch("done_valid", done_valid, w.dv);
                if (turnaround !== w.tat)    report_mismatch("turnaround", turnaround, w.tat);
                if (waiting !== w.wt)        report_mismatch("waiting", waiting, w.wt);
                if (all_done !== w.ad)       report_mismatch("all_done", all_done, w.ad);
                if (table_full !== w.tf)     report_mismatch("table_full", table_full, w.tf);
            end
        end
    end

    // ---------------------------------------------------------------------
    // request driver
    // ---------------------------------------------------------------------

    // present one request at this edge and hold it until the transfer
    task automatic send_req(input logic [REQ_W-1:0] rq, input logic [BURST_W-1:0] b,
                            input logic [TIME_W-1:0] a, input logic [PRIO_W-1:0] p,
                            input bit has_res, input sched_res_t typed);
        sched_res_t r;
        start          <= 1'b1;
        req_type       <= rq;
        burst_time     <= b;
        arrival_time   <= a;
        priority_level <= p;
        do
            @(posedge clk);
        while (busy);
        // transfer at this edge
        r = sched_predict(rq, b, a, p);
        pending_res.push_back(has_res ? typed : r);
    endtask

    // random gap after a transfer; start stays high when there is none
    task automatic idle_gap(input bit allow);
        int g;
        int k;
        k = $urandom_range(0, 9);
        g = !allow ? 0 : (k < 6) ? 0 : (k < 9) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // wait until the block is idle with nothing outstanding, then pause
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_res.size() != 0 || busy)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_SCHED_MODE)
            sh_mode = d[MODE_W-1:0];
        else
            sh_quantum = (d == 0) ? QNT_W'(1) : d;
        @(posedge clk);
    endtask

    function automatic dir_row_t mk_row(input logic [REQ_W-1:0] rq, input int b, input int a,
                                        input int p, input bit has_res, input sched_res_t r);
        dir_row_t d;
        d.req     = rq;
        d.burst   = BURST_W'(b);
        d.arr     = TIME_W'(a);
        d.prio    = PRIO_W'(p);
        d.has_res = has_res;
        d.res     = r;
        return d;
    endfunction

    initial
    begin
        dir_row_t   rows[$];
        sched_res_t r0;
        sched_res_t r_ad;
        sched_res_t r_tf;
        logic [REQ_W-1:0] rq;
        logic [TIME_W-1:0] a;
        int phase;
        int k;
        int q;
        int mode_pick;

        // inputs known from time zero
        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = '0;
        burst_time     = '0;
        arrival_time   = '0;
        priority_level = '0;
        cfg_we         = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        fail_count     = 0;
        cycle_count    = 0;
        sh_count   = '0;
        sh_run_v   = 1'b0;
        sh_run_s   = '0;
        sh_tick    = '0;
        sh_qleft   = QNT_W'(1);
        sh_head    = '0;
        sh_tail    = '0;
        sh_fill    = '0;
        sh_queued  = '0;
        sh_mode    = MODE_FCFS;
        sh_quantum = QNT_W'(1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed table; typed results only where obvious
        r0   = '0;
        r_ad = '0;
        r_ad.ad = 1'b1;
        r_tf = '0;
        r_tf.tf = 1'b1;
        rows.push_back(mk_row(REQ_TICK, 0, 0, 0, 1, r_ad));          // empty table: all done
        rows.push_back(mk_row(REQ_UNDEF, 255, 65535, 255, 1, r0));  // unknown request
        rows.push_back(mk_row(REQ_ADD, 3, 0, 5, 1, r0));
        rows.push_back(mk_row(REQ_ADD, 0, 0, 0, 1, r0));            // zero burst, never runs
        rows.push_back(mk_row(REQ_ADD, 255, 65535, 255, 1, r0));    // field extremes
        rows.push_back(mk_row(REQ_ADD, 1, 0, 0, 1, r0));            // fcfs tie with slot 0
        rows.push_back(mk_row(REQ_ADD, 2, 1, 128, 1, r0));
        for (k = 0; k < 8; k++)
            rows.push_back(mk_row(REQ_TICK, 0, 0, 0, 0, r0));
        rows.push_back(mk_row(REQ_UNDEF, 0, 0, 0, 0, r0));
        rows.push_back(mk_row(REQ_RESTART, 0, 0, 0, 1, r0));        // restart reads back time 0
        for (k = 0; k < 4; k++)
            rows.push_back(mk_row(REQ_TICK, 0, 0, 0, 0, r0));

        foreach (rows[i])
        begin
            send_req(rows[i].req, rows[i].burst, rows[i].arr, rows[i].prio,
                     rows[i].has_res, rows[i].res);
            idle_gap(1);
        end

        // random phases, each under a new register setting
        for (phase = 0; phase < 9; phase++)
        begin
            drain();
            // each defined mode and the quantum extremes first, then random including unknown modes
            mode_pick = (phase < 6) ? phase : $urandom_range(0, 7);
            q = (phase == 0) ? 0 : (phase == 1) ? 255 : (phase == 5) ? 1 : $urandom_range(0, 6);
            cfg_write(CFG_SCHED_MODE, {CFG_DATA_W'($urandom_range(0, 31)) << MODE_W}
                                      | CFG_DATA_W'(mode_pick));
            cfg_write(CFG_TIME_QUANTUM, CFG_DATA_W'(q));
            // restart first so every policy sees the whole task set
            send_req(REQ_RESTART, BURST_W'($urandom), TIME_W'($urandom), PRIO_W'($urandom),
                     0, r0);
            for (k = 0; k < 103; k++)
            begin
                q = $urandom_range(0, 99);
                rq = (q < 80) ? REQ_TICK : (q < 90) ? REQ_ADD : (q < 95) ? REQ_RESTART : REQ_UNDEF;
                // adds that fit mostly get near arrivals; rejected ones toggle the full range
                a = (sh_count < NUM_TASKS && $urandom_range(0, 9) != 0)
                    ? TIME_W'($urandom_range(0, 30)) : TIME_W'($urandom);
                send_req(rq, (sh_count < NUM_TASKS) ? BURST_W'($urandom_range(0, 6))
                                                    : BURST_W'($urandom),
                         a, PRIO_W'($urandom), 0, r0);
                // one phase runs back to back
                idle_gap(phase != 3);
            end
        end

        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
